>>> sv/encoder_count_extender_top_defines.svh
// assertion macros shared by the encoder count extender
`ifndef ENCODER_COUNT_EXTENDER_TOP_DEFINES_SVH
`define ENCODER_COUNT_EXTENDER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define ECE_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("encoder count extender check failed");

// consequent must hold in the cycle after the antecedent
`define ECE_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("encoder count extender check failed");

`endif

>>> sv/ece_pkg.sv
// types and constants of the encoder count extender
`timescale 1ns / 1ps

package ece_pkg;

  localparam int POS_W      = 32;
  localparam int HW_FIELD_W = 16;
  localparam int CMD_W      = 3;
  localparam int DIR_W      = 2;
  localparam int OUT_BITS   = 3 * POS_W + DIR_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 3'd0,
    CMD_UP     = 3'd1,
    CMD_DOWN   = 3'd2,
    CMD_RELOAD = 3'd3,
    CMD_SAMPLE = 3'd4
  } command_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_UNKNOWN  = 2'd0,
    DIR_FORWARD  = 2'd1,
    DIR_BACKWARD = 2'd2
  } dir_t;

  typedef struct packed {
    command_t               command;
    logic [HW_FIELD_W-1:0]  hw_count;
  } item_t;

  typedef struct packed {
    dir_t                   direction;
    logic [POS_W-1:0]       backward_total;
    logic [POS_W-1:0]       forward_total;
    logic signed [POS_W-1:0] position;
  } result_t;

  // handshake control between the input register and the result register
  typedef struct packed {
    logic load;
    logic advance;
  } stage_ctrl_t;

endpackage

>>> sv/encoder_count_extender_top.sv
// top level of the encoder count extender
`timescale 1ns / 1ps

// Extends an up/down hardware encoder count to a signed 32-bit position and
// keeps forward and backward movement totals. Each input beat carries a
// command in s_axis_tuser (start, direction up, direction down, reload match,
// sample; other codes leave the state alone) and the hardware count in
// s_axis_tdata; every input beat gives exactly one output beat with the
// position, both totals and the count direction as they stand after that
// command. Throughput is one beat per clock: the whole state update for an
// event is a single pass of adders between the input register and the
// result register, so a new beat is taken every cycle while the output side
// keeps up. From input acceptance to output valid a beat passes the input
// register, then the result register. The result register parts the two
// sides: while it holds an untaken beat, one more beat can still be accepted
// into the input register. All totals wrap modulo 2^32.

`include "encoder_count_extender_top_defines.svh"

module encoder_count_extender_top #(
  parameter int HW_COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // input event stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ece_pkg::HW_FIELD_W-1:0]   s_axis_tdata,  // [15:0] hw_count
  input  logic [ece_pkg::CMD_W-1:0]        s_axis_tuser,  // [2:0] command
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] position, [63:32] forward_total, [95:64] backward_total,
  // [97:96] direction, [103:98] zero
  output logic [ece_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import ece_pkg::*;

  item_t       item_in, item_held;
  logic        in_valid;
  logic        advance;
  stage_ctrl_t in_ctrl, out_ctrl;
  result_t     result_next, result_held;

  // an event moves into the result register when that slot is free or draining
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign item_in.command  = command_t'(s_axis_tuser);
  assign item_in.hw_count = s_axis_tdata;

  assign in_ctrl.load     = s_axis_tvalid && s_axis_tready;
  assign in_ctrl.advance  = advance;
  assign out_ctrl.load    = advance;
  assign out_ctrl.advance = m_axis_tready;

  ece_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (in_ctrl),
    .item_in  (item_in),
    .item_out (item_held),
    .valid    (in_valid)
  );

  // state is committed on the same edge the result is captured
  ece_core #(
    .HW_COUNT_WIDTH (HW_COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_held),
    .result  (result_next)
  );

  ece_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (out_ctrl),
    .result_in  (result_next),
    .result_out (result_held),
    .valid      (m_axis_tvalid)
  );

  // pack result fields, lowest field first, zero fill to whole bytes
  assign m_axis_tdata = {(OUT_DATA_W - OUT_BITS)'(0), result_held.direction,
                         result_held.backward_total, result_held.forward_total,
                         result_held.position};

  // an empty result register never back-pressures the input
  `ECE_ASSERT_SAME(a_ready_when_out_empty, clk, rst, !m_axis_tvalid, s_axis_tready)

  // an accepted beat is held in the input register on the next cycle
  `ECE_ASSERT_NEXT(a_accept_fills_input, clk, rst, s_axis_tvalid && s_axis_tready, in_valid)

  // the direction code on the output is never the unused value
  `ECE_ASSERT_SAME(a_dir_code_valid, clk, rst, m_axis_tvalid, m_axis_tdata[97:96] != 2'd3)

endmodule

>>> sv/ece_in_reg.sv
// input register holding one accepted event beat
`timescale 1ns / 1ps

module ece_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  ece_pkg::stage_ctrl_t ctrl,
  input  ece_pkg::item_t      item_in,
  output ece_pkg::item_t      item_out,
  output logic                valid
);
  import ece_pkg::*;

  logic valid_next;

  always_comb begin
    valid_next = valid;
    if (ctrl.load) begin
      valid_next = 1'b1;
    end else if (ctrl.advance) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item_out <= item_in;
    end
  end

endmodule

>>> sv/ece_core.sv
// position state and combinational event update
`timescale 1ns / 1ps

module ece_core #(
  parameter int HW_COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  ece_pkg::item_t   item,
  output ece_pkg::result_t result
);
  import ece_pkg::*;

  localparam int UPPER_W = (HW_COUNT_WIDTH < POS_W) ? POS_W - HW_COUNT_WIDTH : 1;
  localparam logic [POS_W-1:0] HW_MASK = (HW_COUNT_WIDTH >= POS_W) ? {POS_W{1'b1}} :
                                         ((POS_W'(1) << HW_COUNT_WIDTH) - POS_W'(1));

  logic [UPPER_W-1:0] upper_count, upper_count_next;
  dir_t               count_direction, count_direction_next;
  logic [POS_W-1:0]   last_position, last_position_next;
  logic [POS_W-1:0]   forward_sum, forward_sum_next;
  logic [POS_W-1:0]   backward_sum, backward_sum_next;

  logic [POS_W-1:0]   hw_masked;
  logic [POS_W-1:0]   hi_cur, hi_new;
  logic [POS_W-1:0]   pos_cur;
  logic [POS_W-1:0]   diff_fwd, diff_bwd;

  assign hw_masked = POS_W'(item.hw_count) & HW_MASK;

  // upper part sits above the counter bits, none when the counter fills the word
  if (HW_COUNT_WIDTH < POS_W) begin : g_upper
    assign hi_cur = POS_W'(upper_count) << HW_COUNT_WIDTH;
    assign hi_new = POS_W'(upper_count_next) << HW_COUNT_WIDTH;
  end else begin : g_no_upper
    assign hi_cur = '0;
    assign hi_new = '0;
  end

  assign pos_cur  = hi_cur | hw_masked;
  assign diff_fwd = pos_cur - last_position;
  assign diff_bwd = last_position - pos_cur;

  always_comb begin
    upper_count_next     = upper_count;
    count_direction_next = count_direction;
    last_position_next   = last_position;
    forward_sum_next     = forward_sum;
    backward_sum_next    = backward_sum;
    case (item.command)
      CMD_START: begin
        last_position_next = pos_cur;
      end
      CMD_UP: begin
        count_direction_next = DIR_FORWARD;
      end
      CMD_DOWN: begin
        count_direction_next = DIR_BACKWARD;
      end
      CMD_RELOAD: begin
        case (count_direction)
          DIR_FORWARD: begin
            upper_count_next = upper_count + UPPER_W'(1);
          end
          DIR_BACKWARD: begin
            upper_count_next = upper_count - UPPER_W'(1);
          end
          default: begin
            // unknown direction: nonzero position means underflow
            if (pos_cur != '0) begin
              upper_count_next     = upper_count - UPPER_W'(1);
              count_direction_next = DIR_BACKWARD;
            end else begin
              upper_count_next     = upper_count + UPPER_W'(1);
              count_direction_next = DIR_FORWARD;
            end
          end
        endcase
      end
      CMD_SAMPLE: begin
        if (diff_fwd != '0) begin
          if (diff_fwd[POS_W-1]) begin
            backward_sum_next = backward_sum + diff_bwd;
          end else begin
            forward_sum_next = forward_sum + diff_fwd;
          end
        end
        last_position_next = pos_cur;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_count     <= '0;
      count_direction <= DIR_UNKNOWN;
      last_position   <= '0;
      forward_sum     <= '0;
      backward_sum    <= '0;
    end else if (advance) begin
      upper_count     <= upper_count_next;
      count_direction <= count_direction_next;
      last_position   <= last_position_next;
      forward_sum     <= forward_sum_next;
      backward_sum    <= backward_sum_next;
    end
  end

  always_comb begin
    result.position       = hi_new | hw_masked;
    result.forward_total  = forward_sum_next;
    result.backward_total = backward_sum_next;
    result.direction      = count_direction_next;
  end

endmodule

>>> sv/ece_out_reg.sv
// result register holding one beat for the output side
`timescale 1ns / 1ps

module ece_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  ece_pkg::stage_ctrl_t ctrl,
  input  ece_pkg::result_t     result_in,
  output ece_pkg::result_t     result_out,
  output logic                 valid
);
  import ece_pkg::*;

  logic valid_next;

  // here advance is the downstream ready: a held beat is taken while it is high
  always_comb begin
    valid_next = valid;
    if (ctrl.load) begin
      valid_next = 1'b1;
    end else if (ctrl.advance) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      result_out <= result_in;
    end
  end

endmodule

>>> test/encoder_count_extender_top_test.sv
// self-checking testbench for the encoder count extender top level
`timescale 1ns / 1ps

module encoder_count_extender_top_test;
  import ece_pkg::*;

  // command codes the block must ignore, still giving one beat back
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam int RESET_CYCLES    = 12;
  localparam int RANDOM_ITEMS    = 1200;
  // reloads needed to move the upper half by half its range
  localparam int HALF_UPPER_SPAN = 32768;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PRESSURE_AFTER  = 500;
  localparam int PRESSURE_HOLD   = 300;
  localparam int RUN_LIMIT_MS    = 100;

  // running copy of the block's state, one expected beat per event
  class position_scoreboard;
    logic [POS_W-HW_FIELD_W-1:0] upper;
    dir_t                        dir;
    logic [POS_W-1:0]            last_pos;
    logic [POS_W-1:0]            fwd_sum;
    logic [POS_W-1:0]            bwd_sum;
    result_t                     pending[$];
    int                          errors;

    function new();
      upper    = '0;
      dir      = DIR_UNKNOWN;
      last_pos = '0;
      fwd_sum  = '0;
      bwd_sum  = '0;
      errors   = 0;
    endfunction

    function logic [POS_W-1:0] extended(logic [HW_FIELD_W-1:0] hw);
      return {upper, hw};
    endfunction

    function void note_event(logic [CMD_W-1:0] cmd, logic [HW_FIELD_W-1:0] hw);
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] delta;
      result_t          want;
      case (cmd)
        CMD_START: last_pos = extended(hw);
        CMD_UP:    dir = DIR_FORWARD;
        CMD_DOWN:  dir = DIR_BACKWARD;
        CMD_RELOAD: begin
          if (dir == DIR_FORWARD) begin
            upper = upper + 1'b1;
          end else if (dir == DIR_BACKWARD) begin
            upper = upper - 1'b1;
          end else if (extended(hw) != '0) begin
            // unknown direction, nonzero position: counter ran under
            upper = upper - 1'b1;
            dir   = DIR_BACKWARD;
          end else begin
            upper = upper + 1'b1;
            dir   = DIR_FORWARD;
          end
        end
        CMD_SAMPLE: begin
          pos   = extended(hw);
          delta = pos - last_pos;
          // sign bit decides the total; most negative delta adds 2^31
          if (delta[POS_W-1]) bwd_sum = bwd_sum - delta;
          else                fwd_sum = fwd_sum + delta;
          last_pos = pos;
        end
        default: ;
      endcase
      want.position       = extended(hw);
      want.forward_total  = fwd_sum;
      want.backward_total = bwd_sum;
      want.direction      = dir;
      pending.push_back(want);
    endfunction

    function void check_beat(logic [OUT_DATA_W-1:0] data);
      result_t got;
      result_t want;
      got = result_t'(data[OUT_BITS-1:0]);
      if (pending.size() == 0) begin
        $error("result beat with nothing outstanding: %0h", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.position !== want.position) begin
        $error("position mismatch: expected %0d, actual %0d", want.position, got.position);
        errors++;
      end
      if (got.forward_total !== want.forward_total) begin
        $error("forward_total mismatch: expected %0d, actual %0d",
               want.forward_total, got.forward_total);
        errors++;
      end
      if (got.backward_total !== want.backward_total) begin
        $error("backward_total mismatch: expected %0d, actual %0d",
               want.backward_total, got.backward_total);
        errors++;
      end
      if (got.direction !== want.direction) begin
        $error("direction mismatch: expected %0d, actual %0d", want.direction, got.direction);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [HW_FIELD_W-1:0] s_axis_tdata = '0;  // [15:0] hw_count
  logic [CMD_W-1:0]      s_axis_tuser = '0;  // [2:0] command
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] position, [63:32] forward_total, [95:64] backward_total, [97:96] direction
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  position_scoreboard sb = new();

  int items_sent = 0;
  int beats_out  = 0;
  bit sender_idles = 1'b1;
  // hardware count as a real encoder would show it during motion sequences
  int enc_hw = 0;

  encoder_count_extender_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // both handshakes are sampled on the edge, before this edge's updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_event(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_beat(m_axis_tdata);
        beats_out++;
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // offer one event beat and hold it until taken; valid stays high between
  // back-to-back beats so it is never dropped and raised in one step
  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [HW_FIELD_W-1:0] hw);
    int gap;
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= hw;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_direction(input bit up);
    if (up) send_event(CMD_UP, '0);
    else    send_event(CMD_DOWN, 16'($urandom_range(0, 65535)));
  endtask

  // well-formed motion: set direction, latch a start, then move the count,
  // with a reload match on every wrap of the hardware counter and samples
  task automatic run_motion();
    int steps;
    int stride;
    int nxt;
    bit up;
    up = $urandom_range(0, 1);
    send_direction(up);
    send_event(CMD_START, 16'(enc_hw));
    steps = $urandom_range(3, 12);
    for (int i = 0; i < steps; i++) begin
      stride = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40000);
      nxt = up ? enc_hw + stride : enc_hw - stride;
      enc_hw = nxt & 16'hFFFF;
      if (nxt > 65535 || nxt < 0) send_event(CMD_RELOAD, 16'(enc_hw));
      if ($urandom_range(0, 2) != 0) send_event(CMD_SAMPLE, 16'(enc_hw));
      if ($urandom_range(0, 9) == 0) begin
        up = !up;
        send_direction(up);
      end
    end
  endtask

  // any command code at all, any count
  task automatic send_noise();
    send_event(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
  endtask

  // result side: random stalls, steady stretches, one long hold-off
  initial begin : result_sink
    int run_len;
    int stall_len;
    bit steady;
    bit pressure_done;
    pressure_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!pressure_done && beats_out >= PRESSURE_AFTER) begin
        // hold off long enough for the block to fill and stall its input
        pressure_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
      end
      steady  = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(10, 60);
      repeat (run_len) begin
        if (steady) begin
          m_axis_tready <= 1'b1;
          @(posedge clk);
        end else if ($urandom_range(0, 19) == 0) begin
          m_axis_tready <= 1'b0;
          stall_len = $urandom_range(8, 20);
          repeat (stall_len) @(posedge clk);
        end else begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int target;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: zero delta straight after reset
    send_event(CMD_SAMPLE, 16'h0000);
    // undefined codes leave the state alone
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      send_event(3'(c), (c == CMD_UNUSED_LO) ? 16'hFFFF : 16'h5555 << (c - CMD_UNUSED_LO));
    end
    // first reload with direction unknown: the seed picks overflow (zero
    // position) or underflow (nonzero position), only one is reachable per run
    if ($urandom_range(0, 1) == 0) send_event(CMD_RELOAD, 16'h0000);
    else                           send_event(CMD_RELOAD, 16'($urandom_range(1, 65535)));
    send_event(CMD_UP, 16'hFFFF);
    send_event(CMD_RELOAD, 16'hFFFF);
    send_event(CMD_RELOAD, 16'h0001);
    send_event(CMD_DOWN, 16'h0000);
    send_event(CMD_RELOAD, 16'h0000);
    send_event(CMD_RELOAD, 16'h8000);
    send_event(CMD_START, 16'hFFFF);
    send_event(CMD_SAMPLE, 16'h0000);
    send_event(CMD_SAMPLE, 16'hFFFF);
    send_event(CMD_SAMPLE, 16'hFFFF);
    send_event(CMD_SAMPLE, 16'h8000);
    send_event(CMD_SAMPLE, 16'h7FFF);

    // most negative delta: move the upper half by half its range in one
    // direction between start and sample, so the delta is exactly -2^31
    send_event(CMD_START, 16'h0000);
    sender_idles = 1'b0;
    repeat (HALF_UPPER_SPAN) send_event(CMD_RELOAD, 16'($urandom_range(0, 65535)));
    sender_idles = 1'b1;
    send_event(CMD_SAMPLE, 16'h0000);
    // and back again the other way: +2^31 has the sign bit set, so it also
    // counts as a most negative delta on the backward total
    send_event(CMD_START, 16'h0000);
    send_event(CMD_UP, 16'h0000);
    sender_idles = 1'b0;
    repeat (HALF_UPPER_SPAN) send_event(CMD_RELOAD, 16'h0000);
    sender_idles = 1'b1;
    send_event(CMD_SAMPLE, 16'h0000);

    // random part: mostly motion sequences, some noise
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      sender_idles = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) send_noise();
      end else begin
        run_motion();
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the monitor note the last accepted beat before draining
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else                $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #(RUN_LIMIT_MS * 1ms);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/ece_pkg.sv
sv/ece_in_reg.sv
sv/ece_core.sv
sv/ece_out_reg.sv
sv/encoder_count_extender_top.sv
test/encoder_count_extender_top_test.sv
